// ----- sv/fwct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwct_pkg
// Types, constants and replacement tables shared by the cache tag directory.
// ----------------------------------------------------------------------------
package fwct_pkg;

    localparam int ADDR_W = 16;
    localparam int WAYS   = 4;
    localparam int WAY_W  = 2;
    localparam int PLRU_W = 3;
    localparam int CNT_W  = 32;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              operation;
    } request_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic             write_back;
        logic [CNT_W-1:0] read_total;
        logic [CNT_W-1:0] write_total;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] write_back_total;
    } result_t;

    // Victim way for each 3-bit tree code.
    localparam logic [WAY_W-1:0] VICTIM_WAY [8] = '{
        2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
    };

    // Next tree code, indexed by {code[1:0], way used}; code bit 2 is not read.
    localparam logic [PLRU_W-1:0] PLRU_NEXT [16] = '{
        3'd6, 3'd4, 3'd1, 3'd0,
        3'd7, 3'd5, 3'd1, 3'd0,
        3'd6, 3'd4, 3'd3, 3'd2,
        3'd7, 3'd5, 3'd3, 3'd2
    };

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value,
                                                 input logic            en);
        logic [CNT_W-1:0] res;
        res = value;
        if (en && (value != {CNT_W{1'b1}}))
        begin
            res = value + CNT_W'(1);
        end
        return res;
    endfunction

endpackage

// ----- sv/four_way_cache_tag_plru_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_way_cache_tag_plru_core
// Tag directory of a write-back 4-way set-associative cache with 8-byte lines,
// tree pseudo-LRU replacement and five saturating access counters.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// request   in         start & !busy        request_t (address, operation)
// result    out        done, one cycle      result_t (hit, way, totals)
//
// One access is taken every cycle while busy is low. The lookup works on the
// registered request and set-RAM row, and the result registers capture its
// outcome; done is high for exactly one cycle per result beat. After reset,
// busy stays high while the set RAM is cleared. The set RAM is read at accept
// and written by the lookup stage; a write to the same set in the previous
// cycle is forwarded. SETS must be a power of two; the block does not enforce
// it. The receiver cannot stall, so busy is low whenever the clear has finished.
// ----------------------------------------------------------------------------
module four_way_cache_tag_plru_core
    import fwct_pkg::*;
#(
    parameter int SETS      = 16,
    parameter int ADDR_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    localparam int EFF_BITS  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int LINE_BITS = EFF_BITS - 3;
    localparam int IDX_BITS  = $clog2(SETS);
    localparam int TAG_RAW   = LINE_BITS - IDX_BITS;
    localparam int TAG_BITS  = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int EXT_W     = LINE_BITS + IDX_BITS + 1;
    localparam int TAGS_W    = WAYS * TAG_BITS;
    localparam int ROW_W     = PLRU_W + 2 * WAYS + TAGS_W;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_BITS-1:0]   clr_idx_reg;

    logic                  req_valid_reg;
    request_t              req_reg;

    logic                  last_valid_reg;
    logic [IDX_BITS-1:0]   last_set_reg;
    logic [ROW_W-1:0]      last_row_reg;

    logic                  done_reg;
    logic                  hit_reg;
    logic [WAY_W-1:0]      way_reg;
    logic                  wb_reg;
    logic [CNT_W-1:0]      rd_cnt_reg, wr_cnt_reg, hit_cnt_reg, miss_cnt_reg, wb_cnt_reg;

    logic [EXT_W-1:0]      in_line;
    logic [EXT_W-1:0]      cur_line;
    logic [IDX_BITS-1:0]   in_set;
    logic [IDX_BITS-1:0]   cur_set;
    logic [TAG_BITS-1:0]   cur_tag;
    logic                  cur_write;

    logic [ROW_W-1:0]      ram_rdata;
    logic [ROW_W-1:0]      cur_row;
    logic [ROW_W-1:0]      new_row;
    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_waddr;
    logic [ROW_W-1:0]      ram_wdata;

    logic [PLRU_W-1:0]     plru_cur;
    logic [WAYS-1:0]       valid_cur;
    logic [WAYS-1:0]       dirty_cur;
    logic [TAG_BITS-1:0]   tag_cur [WAYS];
    logic [WAYS-1:0]       hit_vec;
    logic                  lk_hit;
    logic [WAY_W-1:0]      hit_way;
    logic [WAY_W-1:0]      fill_way;
    logic [WAY_W-1:0]      use_way;
    logic                  lk_wb;
    logic [PLRU_W-1:0]     plru_new;
    logic [WAYS-1:0]       valid_new;
    logic [WAYS-1:0]       dirty_new;
    logic [TAGS_W-1:0]     tags_new;

    assign busy      = (state_reg == ST_CLEAR);
    assign in_line   = EXT_W'(request.address[EFF_BITS-1:3]);
    assign in_set    = in_line[IDX_BITS-1:0];
    assign cur_line  = EXT_W'(req_reg.address[EFF_BITS-1:3]);
    assign cur_set   = cur_line[IDX_BITS-1:0];
    assign cur_tag   = cur_line[IDX_BITS +: TAG_BITS];
    assign cur_write = (req_reg.operation == OP_WRITE);

    fwct_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_set_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (in_set),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == IDX_BITS'(SETS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cur_row   = (last_valid_reg && (last_set_reg == cur_set)) ? last_row_reg : ram_rdata;
        plru_cur  = cur_row[ROW_W-1 -: PLRU_W];
        valid_cur = cur_row[TAGS_W + WAYS +: WAYS];
        dirty_cur = cur_row[TAGS_W +: WAYS];
        for (int w = 0; w < WAYS; w++)
        begin
            tag_cur[w] = cur_row[w*TAG_BITS +: TAG_BITS];
            hit_vec[w] = valid_cur[w] && (tag_cur[w] == cur_tag);
        end
        lk_hit = |hit_vec;

        hit_way  = '0;
        fill_way = VICTIM_WAY[plru_cur];
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (!valid_cur[w])
            begin
                fill_way = WAY_W'(w);
            end
        end
        use_way = lk_hit ? hit_way : fill_way;
        lk_wb   = !lk_hit && valid_cur[fill_way] && dirty_cur[fill_way];

        plru_new  = PLRU_NEXT[{plru_cur[1:0], use_way}];
        valid_new = valid_cur;
        dirty_new = dirty_cur;
        valid_new[use_way] = 1'b1;
        dirty_new[use_way] = cur_write || (lk_hit && dirty_cur[use_way]);
        for (int w = 0; w < WAYS; w++)
        begin
            tags_new[w*TAG_BITS +: TAG_BITS] =
                (WAY_W'(w) == use_way) ? cur_tag : tag_cur[w];
        end
        new_row = {plru_new, valid_new, dirty_new, tags_new};

        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = req_valid_reg;
            ram_waddr = cur_set;
            ram_wdata = new_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            req_valid_reg  <= 1'b0;
            last_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            rd_cnt_reg     <= '0;
            wr_cnt_reg     <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            wb_cnt_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= (state_reg == ST_CLEAR) ? clr_idx_reg + IDX_BITS'(1) : clr_idx_reg;
            req_valid_reg  <= start && !busy;
            last_valid_reg <= req_valid_reg;
            done_reg       <= req_valid_reg;
            if (req_valid_reg)
            begin
                rd_cnt_reg   <= sat_inc(rd_cnt_reg, !cur_write);
                wr_cnt_reg   <= sat_inc(wr_cnt_reg, cur_write);
                hit_cnt_reg  <= sat_inc(hit_cnt_reg, lk_hit);
                miss_cnt_reg <= sat_inc(miss_cnt_reg, !lk_hit);
                wb_cnt_reg   <= sat_inc(wb_cnt_reg, lk_wb);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        if (req_valid_reg)
        begin
            last_set_reg <= cur_set;
            last_row_reg <= new_row;
            hit_reg      <= lk_hit;
            way_reg      <= use_way;
            wb_reg       <= lk_wb;
        end
    end

    assign done = done_reg;

    always_comb
    begin
        result.hit              = hit_reg;
        result.way              = way_reg;
        result.write_back       = wb_reg;
        result.read_total       = rd_cnt_reg;
        result.write_total      = wr_cnt_reg;
        result.hit_total        = hit_cnt_reg;
        result.miss_total       = miss_cnt_reg;
        result.write_back_total = wb_cnt_reg;
    end

`ifndef SYNTHESIS
    // Every accepted access yields a result beat once it has passed the lookup and the result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted access produced no result beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result beat without an accepted access");

    // Once the clear pass is over the directory never becomes busy again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |=> (state_reg == ST_RUN))
        else $error("directory returned to the clear pass");

    // A write-back only happens on a miss and is always counted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.write_back) |-> (!result.hit && (result.write_back_total != '0)))
        else $error("write-back on a hit or not counted");
`endif

endmodule

// ----- sv/fwct_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwct_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fwct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
